[src/sbrag_pkg.sv]
// ----------------------------------------------------------------------------
// sbrag_pkg
// Shared types, widths and constants of the sub-block row address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrag_pkg;

	// Counter range and dimension limit
	localparam int EXTENT_BITS = 12;
	localparam int MAX_DIMS    = 4;

	// Field widths
	localparam int NDIM_W  = 3;
	localparam int ELEM_W  = 4;
	localparam int EXT_W   = 13;
	localparam int START_W = 12;
	localparam int OFF_W   = 51;
	localparam int RUN_W   = 16;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Derived widths
	localparam int CNT_W   = EXTENT_BITS;
	localparam int IDX_W   = ((START_W > CNT_W) ? START_W : CNT_W) + 1;
	localparam int LIM_W   = ((CNT_W + 1) > EXT_W) ? (CNT_W + 1) : EXT_W;
	localparam int PROD_W  = EXT_W + ELEM_W;
	localparam int B_W     = 2 * EXT_W;
	localparam int C_W     = 3 * EXT_W;
	localparam int SPLIT   = 2 * EXT_W;
	localparam int C_HI_W  = C_W - SPLIT;
	localparam int T2_W    = IDX_W + EXT_W;
	localparam int T1_W    = IDX_W + B_W;
	localparam int PLO_W   = IDX_W + SPLIT;
	localparam int PHI_W   = IDX_W + C_HI_W;

	localparam logic [LIM_W-1:0] CNT_LIMIT = LIM_W'(1) << CNT_W;
	localparam logic [RUN_W-1:0] RUN_MAX   = '1;

	// Request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_NEXT  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [START_W-1:0] rel_start_0;
		logic [START_W-1:0] rel_start_1;
		logic [START_W-1:0] rel_start_2;
		logic [START_W-1:0] rel_start_3;
		logic [EXT_W-1:0]   sub_extent_0;
		logic [EXT_W-1:0]   sub_extent_1;
		logic [EXT_W-1:0]   sub_extent_2;
		logic [EXT_W-1:0]   sub_extent_3;
	} req_item_t;

	typedef struct packed {
		logic [OFF_W-1:0] src_offset;
		logic [OFF_W-1:0] dst_offset;
		logic [RUN_W-1:0] run_bytes;
		logic             last_run;
	} run_item_t;

	typedef struct packed {
		logic [NDIM_W-1:0] dim_count;
		logic [ELEM_W-1:0] elem_bytes;
		logic [EXT_W-1:0]  src_extent_1;
		logic [EXT_W-1:0]  src_extent_2;
		logic [EXT_W-1:0]  src_extent_3;
	} cfg_t;

	// Fields that ride along the address pipeline unchanged
	typedef struct packed {
		logic [ELEM_W-1:0] eb;
		logic [RUN_W-1:0]  run;
		logic [OFF_W-1:0]  dst;
		logic              last;
	} tail_t;

	// One run, right-aligned: slot 3 is the innermost dimension
	typedef struct packed {
		logic [IDX_W-1:0]   idx0;
		logic [IDX_W-1:0]   idx1;
		logic [IDX_W-1:0]   idx2;
		logic [START_W-1:0] idx3;
		logic [EXT_W-1:0]   e0;
		logic [EXT_W-1:0]   e1;
		logic [EXT_W-1:0]   e2;
		tail_t              tail;
	} desc_t;

endpackage

`default_nettype wire

[src/sbrag_cfg.sv]
// ----------------------------------------------------------------------------
// sbrag_cfg
// APB register file: dimension count, element size and source extents.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrag_cfg import sbrag_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	localparam logic [2:0] REG_DIM_COUNT  = 3'd0;
	localparam logic [2:0] REG_ELEM_BYTES = 3'd1;
	localparam logic [2:0] REG_SRC_EXT_1  = 3'd2;
	localparam logic [2:0] REG_SRC_EXT_2  = 3'd3;
	localparam logic [2:0] REG_SRC_EXT_3  = 3'd4;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_count    <= NDIM_W'(1);
			cfg_q.elem_bytes   <= ELEM_W'(1);
			cfg_q.src_extent_1 <= EXT_W'(1);
			cfg_q.src_extent_2 <= EXT_W'(1);
			cfg_q.src_extent_3 <= EXT_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_DIM_COUNT:  cfg_q.dim_count    <= pwdata[NDIM_W-1:0];
				REG_ELEM_BYTES: cfg_q.elem_bytes   <= pwdata[ELEM_W-1:0];
				REG_SRC_EXT_1:  cfg_q.src_extent_1 <= pwdata[EXT_W-1:0];
				REG_SRC_EXT_2:  cfg_q.src_extent_2 <= pwdata[EXT_W-1:0];
				REG_SRC_EXT_3:  cfg_q.src_extent_3 <= pwdata[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_DIM_COUNT:  prdata = DATA_W'(cfg_q.dim_count);
			REG_ELEM_BYTES: prdata = DATA_W'(cfg_q.elem_bytes);
			REG_SRC_EXT_1:  prdata = DATA_W'(cfg_q.src_extent_1);
			REG_SRC_EXT_2:  prdata = DATA_W'(cfg_q.src_extent_2);
			REG_SRC_EXT_3:  prdata = DATA_W'(cfg_q.src_extent_3);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/sbrag_ctrl.sv]
// ----------------------------------------------------------------------------
// sbrag_ctrl
// Request state, outer counters and destination offset; builds one run
// descriptor per next word while a sub-block is active.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrag_ctrl import sbrag_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      accept,
	input  wire req_item_t item,
	output desc_t          desc,
	output logic           produce
);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q [3];
	logic [OFF_W-1:0]    dst_q;
	logic [START_W-1:0]  rs_q [4];
	logic [EXT_W-1:0]    ext_q [4];

	logic                start;
	logic [1:0]          inner;
	logic [LIM_W-1:0]    lim [3];
	logic [2:0]          room;
	logic [2:0]          active;
	logic                last;
	logic [CNT_W-1:0]    cnt_nxt [3];
	logic [PROD_W-1:0]   prod;
	logic [RUN_W-1:0]    run;
	logic [EXT_W-1:0]    ext_a [4];
	logic [IDX_W-1:0]    idx [3];

	assign start   = accept && (item.req_type == REQ_START);
	assign produce = accept && (item.req_type == REQ_NEXT) && busy_q;

	// innermost dimension from the clamped dimension count
	always_comb begin
		if (cfg.dim_count == '0) begin
			inner = 2'd0;
		end else if (cfg.dim_count > NDIM_W'(MAX_DIMS)) begin
			inner = 2'(MAX_DIMS - 1);
		end else begin
			inner = 2'(cfg.dim_count - NDIM_W'(1));
		end
	end

	// outer limits, last-run detect and counter advance
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int d = 0; d < 3; d++) begin
			if (LIM_W'(ext_q[d]) == '0) begin
				lim[d] = LIM_W'(1);
			end else if (LIM_W'(ext_q[d]) > CNT_LIMIT) begin
				lim[d] = CNT_LIMIT;
			end else begin
				lim[d] = LIM_W'(ext_q[d]);
			end
			room[d]   = (LIM_W'(cnt_q[d]) + LIM_W'(1)) < lim[d];
			active[d] = 2'(d) < inner;
		end
		last = &(~room | ~active);
		for (int d = 2; d >= 0; d--) begin
			cnt_nxt[d] = cnt_q[d];
			if (active[d] && carry) begin
				if (room[d]) begin
					cnt_nxt[d] = cnt_q[d] + CNT_W'(1);
					carry      = 1'b0;
				end else begin
					cnt_nxt[d] = '0;
				end
			end
		end
	end

	// run length, saturated to the field
	assign prod = PROD_W'(ext_q[inner]) * PROD_W'(cfg.elem_bytes);
	assign run  = (prod > PROD_W'(RUN_MAX)) ? RUN_MAX : prod[RUN_W-1:0];

	// right-align dimensions into fixed slots
	always_comb begin
		logic [1:0] d;
		ext_a[0] = EXT_W'(1);
		ext_a[1] = cfg.src_extent_1;
		ext_a[2] = cfg.src_extent_2;
		ext_a[3] = cfg.src_extent_3;
		for (int s = 0; s < 3; s++) begin
			d = 2'(s + int'(inner) - 3);
			if ((s + int'(inner)) >= 3) begin
				idx[s] = IDX_W'(rs_q[d]) + IDX_W'(cnt_q[d]);
			end else begin
				idx[s] = '0;
			end
		end
		desc.idx0      = idx[0];
		desc.idx1      = idx[1];
		desc.idx2      = idx[2];
		desc.idx3      = rs_q[inner];
		desc.e2        = ext_a[inner];
		desc.e1        = (inner >= 2'd1) ? ext_a[inner - 2'd1] : EXT_W'(1);
		desc.e0        = (inner >= 2'd2) ? ext_a[inner - 2'd2] : EXT_W'(1);
		desc.tail.eb   = cfg.elem_bytes;
		desc.tail.run  = run;
		desc.tail.dst  = dst_q;
		desc.tail.last = last;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dst_q  <= '0;
			for (int d = 0; d < 3; d++) cnt_q[d] <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			dst_q  <= '0;
			for (int d = 0; d < 3; d++) cnt_q[d] <= '0;
		end else if (produce) begin
			dst_q <= dst_q + OFF_W'(run);
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				for (int d = 0; d < 3; d++) cnt_q[d] <= cnt_nxt[d];
			end
		end
	end

	// saved request
	always_ff @(posedge clk) begin
		if (start) begin
			rs_q[0]  <= item.rel_start_0;
			rs_q[1]  <= item.rel_start_1;
			rs_q[2]  <= item.rel_start_2;
			rs_q[3]  <= item.rel_start_3;
			ext_q[0] <= item.sub_extent_0;
			ext_q[1] <= item.sub_extent_1;
			ext_q[2] <= item.sub_extent_2;
			ext_q[3] <= item.sub_extent_3;
		end
	end

	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("busy not set after start");

	a_last_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && last) |=> !busy_q)
		else $error("busy still set after last run");

endmodule

`default_nettype wire

[src/sbrag_dp.sv]
// ----------------------------------------------------------------------------
// sbrag_dp
// Source offset pipeline: strides, per-dimension products, sum and scale
// by element size, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrag_dp import sbrag_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire desc_t desc,
	input  wire logic  produce,
	output logic       take_ready,
	output logic       run_valid,
	input  wire logic  run_ready,
	output run_item_t  run_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	desc_t              desc_s1;
	logic [T2_W-1:0]    t2_s2, t2_s3;
	logic [B_W-1:0]     b_s2;
	logic [EXT_W-1:0]   e0_s2;
	logic [IDX_W-1:0]   idx0_s2, idx1_s2, idx0_s3;
	logic [START_W-1:0] idx3_s2, idx3_s3;
	logic [C_W-1:0]     c_s3;
	logic [T1_W-1:0]    t1_s3;
	logic [PLO_W-1:0]   plo_s4;
	logic [PHI_W-1:0]   phi_s4, phi_s5;
	logic [OFF_W-1:0]   sum_s4, part_s5, elems_s6;
	tail_t              tail_s2, tail_s3, tail_s4, tail_s5, tail_s6;
	run_item_t          run_s7;
	logic [OFF_W-1:0]   src_scaled;

	// stall chain: a stage moves when it is empty or the next one moves
	assign en7        = !v_s7 || run_ready;
	assign en6        = !v_s6 || en7;
	assign en5        = !v_s5 || en6;
	assign en4        = !v_s4 || en5;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign take_ready = en1;

	assign run_valid = v_s7;
	assign run_data  = run_s7;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= produce;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// elem_bytes scaling as four shifted adds
	always_comb begin
		src_scaled = '0;
		for (int i = 0; i < ELEM_W; i++) begin
			if (tail_s6.eb[i]) src_scaled = src_scaled + (elems_s6 << i);
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		// s1: descriptor
		if (en1) desc_s1 <= desc;
		// s2: two-dimension stride, innermost outer term
		if (en2) begin
			b_s2    <= B_W'(desc_s1.e1) * B_W'(desc_s1.e2);
			t2_s2   <= T2_W'(desc_s1.idx2) * T2_W'(desc_s1.e2);
			e0_s2   <= desc_s1.e0;
			idx0_s2 <= desc_s1.idx0;
			idx1_s2 <= desc_s1.idx1;
			idx3_s2 <= desc_s1.idx3;
			tail_s2 <= desc_s1.tail;
		end
		// s3: three-dimension stride, middle term
		if (en3) begin
			c_s3    <= C_W'(e0_s2) * C_W'(b_s2);
			t1_s3   <= T1_W'(idx1_s2) * T1_W'(b_s2);
			t2_s3   <= t2_s2;
			idx0_s3 <= idx0_s2;
			idx3_s3 <= idx3_s2;
			tail_s3 <= tail_s2;
		end
		// s4: outermost term as two partial products, sum of the rest
		if (en4) begin
			plo_s4  <= PLO_W'(idx0_s3) * PLO_W'(c_s3[SPLIT-1:0]);
			phi_s4  <= PHI_W'(idx0_s3) * PHI_W'(c_s3[C_W-1:SPLIT]);
			sum_s4  <= OFF_W'(idx3_s3) + OFF_W'(t1_s3) + OFF_W'(t2_s3);
			tail_s4 <= tail_s3;
		end
		// s5: add low partial
		if (en5) begin
			part_s5 <= sum_s4 + OFF_W'(plo_s4);
			phi_s5  <= phi_s4;
			tail_s5 <= tail_s4;
		end
		// s6: add high partial, element index complete
		if (en6) begin
			elems_s6 <= part_s5 + (OFF_W'(phi_s5) << SPLIT);
			tail_s6  <= tail_s5;
		end
		// s7: result register
		if (en7) begin
			run_s7.src_offset <= src_scaled;
			run_s7.dst_offset <= tail_s6.dst;
			run_s7.run_bytes  <= tail_s6.run;
			run_s7.last_run   <= tail_s6.last;
		end
	end

	a_s6_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && en6) |=> v_s7)
		else $error("run lost between last stage and result register");

	a_full_blocks_take: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !run_ready) |-> !take_ready)
		else $error("new run taken while pipeline full and stalled");

endmodule

`default_nettype wire

[src/subblock_row_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// subblock_row_address_generator_unit
// Row-copy descriptor generator for 1 to 4 dimensional sub-blocks.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req_data): a start word latches the
//    sub-block start and extents and produces nothing; each next word while
//    a sub-block is active yields one run word. Next words while idle are
//    taken and dropped.
//  - run channel (run_valid/run_ready/run_data): source offset, destination
//    offset, run length and a last-run flag. After the last run the block
//    goes idle until the next start.
//  - APB port holds the dimension count, elem_bytes and source extents 1..3.
//  - Pipeline: a run word passes the descriptor register, the stride and
//    product stages and the result register after its next word is taken.
//  - Throughput: one word per cycle unless run_ready stalls the pipeline;
//    the counter step is registered; offset math spans the pipeline stages.
//  - Stall: when run_ready is low the result register holds; the stages
//    behind it keep filling and req_ready drops only when all are full.
//  - Reset: idle, counters and destination offset cleared, registers at
//    their defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module subblock_row_address_generator_unit import sbrag_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_item_t         req_data,
	output logic                   run_valid,
	input  wire logic              run_ready,
	output run_item_t              run_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t  cfg;
	desc_t desc;
	logic  produce;
	logic  accept;

	assign accept = req_valid && req_ready;

	sbrag_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbrag_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.item    (req_data),
		.desc    (desc),
		.produce (produce)
	);

	sbrag_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (desc),
		.produce    (produce),
		.take_ready (req_ready),
		.run_valid  (run_valid),
		.run_ready  (run_ready),
		.run_data   (run_data)
	);

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sub-block row address generator.
// Start and next words go in with random gaps, and the register file is
// reprogrammed over APB between phases. Every run word that comes out is
// compared field by field against a row walk kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbrag_pkg::*;

	// Register map, one 32-bit register per word address
	typedef enum logic [ADDR_W-1:0] {
		REG_DIM_COUNT  = 5'd0,
		REG_ELEM_BYTES = 5'd4,
		REG_SRC_EXT_1  = 5'd8,
		REG_SRC_EXT_2  = 5'd12,
		REG_SRC_EXT_3  = 5'd16
	} reg_addr_t;

	localparam int GAP_MAX      = 10;
	localparam int DRAIN_WAIT   = 12;   // run pipeline is 7 deep
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_OFF     = 300;
	localparam int RANDOM_WORDS = 1500;
	localparam int TO_THE_END   = 1 << 30;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_item_t         req_data  = '0;
	logic              run_valid;
	logic              run_ready = 1'b0;
	run_item_t         run_data;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Row walk state as the bench sees it
	bit                 gen_busy;
	logic [CNT_W-1:0]   row_count   [3];
	logic [OFF_W-1:0]   dst_acc;
	logic [START_W-1:0] held_start  [4];
	logic [EXT_W-1:0]   held_extent [4];

	// Register shadow
	logic [NDIM_W-1:0]  cfg_ndims;
	logic [ELEM_W-1:0]  cfg_elem;
	logic [EXT_W-1:0]   cfg_src_ext [1:3];

	run_item_t pending_runs [$];
	int        mismatch_count = 0;
	int        useful_words   = 0;
	int        hold_request   = 0;
	int        stall_cycles   = 0;
	bit        quiet_mode     = 1'b0;

	subblock_row_address_generator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run_data  (run_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// Stall watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (run_valid && run_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Row walk prediction
	// ------------------------------------------------------------------------
	function automatic int unsigned live_dims();
		if (cfg_ndims == 0)
			return 1;
		if (cfg_ndims > MAX_DIMS)
			return MAX_DIMS;
		return 32'(cfg_ndims);
	endfunction

	// Row count of an outer dimension, clamped to 1 .. 2^EXTENT_BITS
	function automatic int unsigned outer_span(input int d);
		int unsigned e;
		e = 32'(held_extent[d]);
		if (e == 0)
			e = 1;
		if (e > (1 << EXTENT_BITS))
			e = 1 << EXTENT_BITS;
		return e;
	endfunction

	// Applies one request word; returns 1 with the run word it yields
	function automatic bit predict_run(input req_item_t w, output run_item_t r);
		int          inner;
		logic [63:0] elems;
		logic [63:0] stride;
		logic [63:0] run;
		bit          fin;
		bit          carried;
		r = '0;
		if (w.req_type == REQ_START) begin
			held_start  = '{w.rel_start_0, w.rel_start_1, w.rel_start_2, w.rel_start_3};
			held_extent = '{w.sub_extent_0, w.sub_extent_1, w.sub_extent_2, w.sub_extent_3};
			row_count   = '{default: '0};
			dst_acc     = '0;
			gen_busy    = 1'b1;
			return 1'b0;
		end
		if (!gen_busy)
			return 1'b0;

		// element index, innermost dimension first; 64-bit math, wrapped at the end
		inner  = int'(live_dims()) - 1;
		elems  = 64'(held_start[inner]);
		stride = 64'd1;
		for (int k = inner - 1; k >= 0; k--) begin
			stride = stride * 64'(cfg_src_ext[k + 1]);
			elems  = elems + (64'(held_start[k]) + 64'(row_count[k])) * stride;
		end

		run = 64'(held_extent[inner]) * 64'(cfg_elem);
		if (run > 64'hFFFF)
			run = 64'hFFFF;

		fin = 1'b1;
		for (int k = 0; k < inner; k++)
			if (row_count[k] + 1 < outer_span(k))
				fin = 1'b0;

		r.src_offset = OFF_W'(elems * 64'(cfg_elem));
		r.dst_offset = dst_acc;
		r.run_bytes  = run[RUN_W-1:0];
		r.last_run   = fin;
		dst_acc      = dst_acc + run[RUN_W-1:0];

		// odometer step, dimension inner-1 fastest
		if (fin) begin
			gen_busy = 1'b0;
		end else begin
			carried = 1'b0;
			for (int k = inner - 1; k >= 0; k--) begin
				if (!carried) begin
					if (row_count[k] + 1 < outer_span(k)) begin
						row_count[k] = row_count[k] + 1'b1;
						carried      = 1'b1;
					end else begin
						row_count[k] = '0;
					end
				end
			end
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Word builders
	// ------------------------------------------------------------------------
	function automatic req_item_t random_word(input logic kind);
		req_item_t w;
		w.req_type     = kind;
		w.rel_start_0  = START_W'($urandom);
		w.rel_start_1  = START_W'($urandom);
		w.rel_start_2  = START_W'($urandom);
		w.rel_start_3  = START_W'($urandom);
		w.sub_extent_0 = EXT_W'($urandom);
		w.sub_extent_1 = EXT_W'($urandom);
		w.sub_extent_2 = EXT_W'($urandom);
		w.sub_extent_3 = EXT_W'($urandom);
		return w;
	endfunction

	function automatic req_item_t start_word(
		input logic [START_W-1:0] s0, s1, s2, s3,
		input logic [EXT_W-1:0]   e0, e1, e2, e3);
		req_item_t w;
		w.req_type     = REQ_START;
		w.rel_start_0  = s0;
		w.rel_start_1  = s1;
		w.rel_start_2  = s2;
		w.rel_start_3  = s3;
		w.sub_extent_0 = e0;
		w.sub_extent_1 = e1;
		w.sub_extent_2 = e2;
		w.sub_extent_3 = e3;
		return w;
	endfunction

	function automatic logic [EXT_W-1:0] pick_src_extent();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return EXT_W'(1);
			2:       return EXT_W'(4096);
			3:       return '1;
			4:       return EXT_W'($urandom);
			default: return EXT_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return ELEM_W'($urandom_range(9, 14));
			default: return ELEM_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Outer extents stay small so a block is a handful of runs
	function automatic logic [EXT_W-1:0] pick_outer_extent();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return EXT_W'($urandom_range(4, 12));
			default: return EXT_W'($urandom_range(1, 3));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	// Sends one request word and records what it should produce
	task automatic send_req(input req_item_t w);
		run_item_t r;
		int        gap;
		gap = quiet_mode ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= w;
		do @(posedge clk); while (!req_ready);
		if (w.req_type == REQ_START || gen_busy)
			useful_words++;
		if (predict_run(w, r))
			pending_runs.push_back(r);
	endtask

	// Start a block, then ask for runs until it ends or max_next is reached
	task automatic run_block(input req_item_t start, input int max_next);
		int sent;
		send_req(start);
		sent = 0;
		while (gen_busy && sent < max_next) begin
			send_req(random_word(REQ_NEXT));
			sent++;
		end
	endtask

	// Wait until every run word is in and the pipeline is empty
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// APB register writes
	// ------------------------------------------------------------------------
	task automatic write_reg(input reg_addr_t addr, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			REG_DIM_COUNT:  cfg_ndims      = value[NDIM_W-1:0];
			REG_ELEM_BYTES: cfg_elem       = value[ELEM_W-1:0];
			REG_SRC_EXT_1:  cfg_src_ext[1] = value[EXT_W-1:0];
			REG_SRC_EXT_2:  cfg_src_ext[2] = value[EXT_W-1:0];
			REG_SRC_EXT_3:  cfg_src_ext[3] = value[EXT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_block(input logic [DATA_W-1:0] ndims, elem, e1, e2, e3);
		settle();
		write_reg(REG_DIM_COUNT, ndims);
		write_reg(REG_ELEM_BYTES, elem);
		write_reg(REG_SRC_EXT_1, e1);
		write_reg(REG_SRC_EXT_2, e2);
		write_reg(REG_SRC_EXT_3, e3);
	endtask

	// ------------------------------------------------------------------------
	// Run side: random stalls, optional long hold-off, checks each word
	// ------------------------------------------------------------------------
	function automatic void report_field(input string name, input logic [63:0] want, got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h got %h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_run(input run_item_t got);
		run_item_t want;
		if (pending_runs.size() == 0) begin
			$display("%0t ns: run word expected none got %h", $time, got);
			mismatch_count++;
			return;
		end
		want = pending_runs.pop_front();
		report_field("src_offset", 64'(want.src_offset), 64'(got.src_offset));
		report_field("dst_offset", 64'(want.dst_offset), 64'(got.dst_offset));
		report_field("run_bytes", 64'(want.run_bytes), 64'(got.run_bytes));
		report_field("last_run", 64'(want.last_run), 64'(got.last_run));
	endfunction

	initial begin
		int gap;
		forever begin
			if (hold_request > 0) begin
				gap          = hold_request;
				hold_request = 0;
				run_ready   <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			gap = quiet_mode ? 0 : $urandom_range(0, GAP_MAX);
			if (gap > 0) begin
				run_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			run_ready <= 1'b1;
			do @(posedge clk); while (!run_valid && hold_request == 0);
			if (run_valid)
				check_run(run_data);
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Registers at their reset values: one dimension, one-byte elements
	task automatic test_reset_defaults();
		send_req(random_word(REQ_NEXT));   // nothing active: dropped
		run_block(start_word(12'hFFF, '0, '0, '0, 13'd1, '1, '1, '1), 4);
		send_req(random_word(REQ_NEXT));   // block ended on its last run
		run_block(start_word('0, '1, '1, '1, 13'd4096, '0, '0, '0), 4);
	endtask

	// Dimension counts 0, 2, 3, 4 and 7, including the clamped ones 0 and 7
	task automatic test_dimension_modes();
		program_block(0, 8, 1, 1, 1);   // zero dims behaves as one
		run_block(start_word(12'd7, '0, '0, '0, 13'd5, 13'd9, 13'd9, 13'd9), 2);
		program_block(2, 3, 100, 1, 1);
		run_block(start_word(12'd10, 12'd20, '0, '0, 13'd3, 13'd6, '0, '0), 8);
		program_block(3, 2, 50, 40, 1);
		run_block(start_word(12'd1, 12'd2, 12'd3, '0, 13'd2, 13'd2, 13'd7, '0), 8);
		program_block(4, 4, 30, 20, 10);
		run_block(start_word(12'd1, 12'd2, 12'd3, 12'd4, 13'd2, 13'd1, 13'd2, 13'd5), 8);
		program_block(7, 1, 30, 20, 10);   // above four behaves as four
		run_block(start_word('1, '1, '1, '1, 13'd1, 13'd2, 13'd1, 13'd3), 8);
	endtask

	task automatic test_special_cases();
		program_block(2, 8, 8191, 1, 1);
		// outer extent zero counts as one row
		run_block(start_word(12'd5, 12'd6, '0, '0, '0, 13'd4, '0, '0), 4);
		// a new start drops the active block after one run
		run_block(start_word(12'd1, 12'd1, '0, '0, 13'd5, 13'd4, '0, '0), 1);
		run_block(start_word(12'd2, 12'd2, '0, '0, 13'd2, 13'd8191, '0, '0), 4);
		// run length saturates, then zero inner extent
		program_block(1, 15, 1, 1, 1);
		run_block(start_word('0, '0, '0, '0, 13'd8191, '0, '0, '0), 2);
		run_block(start_word(12'd3, '0, '0, '0, '0, '0, '0, '0), 2);
		// zero-byte elements
		program_block(1, 0, 1, 1, 1);
		run_block(start_word(12'd9, '0, '0, '0, 13'd100, '0, '0, '0), 2);
		// source offset wraps past 51 bits
		program_block(4, 15, 8191, 8191, 8191);
		run_block(start_word('1, '1, '1, '1, 13'd1, 13'd2, 13'd1, 13'd8191), 4);
	endtask

	// An outer extent past 4096 keeps counting rows instead of ending early
	task automatic test_outer_clamp();
		program_block(2, 1, 3, 1, 1);
		quiet_mode = 1'b1;
		run_block(start_word('0, 12'd1, '0, '0, 13'd4097, 13'd1, '0, '0), 16);
		quiet_mode = 1'b0;
	endtask

	// Sink holds off while the source keeps offering next words
	task automatic test_backpressure();
		program_block(3, 2, 16, 16, 1);
		quiet_mode   = 1'b1;
		hold_request = HOLD_OFF;
		run_block(start_word(12'd3, 12'd4, 12'd5, '0, 13'd6, 13'd6, 13'd9, '0), TO_THE_END);
		quiet_mode = 1'b0;
		run_block(start_word(12'd7, 12'd0, 12'd1, '0, 13'd4, 13'd5, 13'd3, '0), TO_THE_END);
	endtask

	// Phases of random settings, mostly complete blocks plus noise
	task automatic test_random_traffic();
		int               goal;
		int               blocks;
		int               kind;
		int               inner;
		logic [EXT_W-1:0] ext [4];
		goal = useful_words + RANDOM_WORDS;
		while (useful_words < goal) begin
			program_block($urandom_range(0, 7), DATA_W'(pick_elem()),
				DATA_W'(pick_src_extent()), DATA_W'(pick_src_extent()),
				DATA_W'(pick_src_extent()));
			quiet_mode = ($urandom_range(0, 4) == 0);
			inner      = int'(live_dims()) - 1;
			blocks     = $urandom_range(4, 10);
			repeat (blocks) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					send_req(random_word(REQ_NEXT));
				end else if (kind == 1) begin
					// arbitrary start, cut short by the next one
					run_block(random_word(REQ_START), $urandom_range(0, 4));
				end else begin
					for (int d = 0; d < 4; d++) begin
						if (d < inner)
							ext[d] = pick_outer_extent();
						else if (d == inner)
							ext[d] = $urandom_range(0, 1) ? EXT_W'($urandom)
								: EXT_W'($urandom_range(1, 64));
						else
							ext[d] = EXT_W'($urandom);
					end
					run_block(start_word(START_W'($urandom), START_W'($urandom),
						START_W'($urandom), START_W'($urandom),
						ext[0], ext[1], ext[2], ext[3]),
						($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : TO_THE_END);
				end
			end
		end
		quiet_mode = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		gen_busy    = 1'b0;
		dst_acc     = '0;
		row_count   = '{default: '0};
		held_start  = '{default: '0};
		held_extent = '{default: '0};
		cfg_ndims   = NDIM_W'(1);
		cfg_elem    = ELEM_W'(1);
		cfg_src_ext = '{EXT_W'(1), EXT_W'(1), EXT_W'(1)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_dimension_modes();
		test_special_cases();
		test_outer_clamp();
		test_backpressure();
		test_random_traffic();
		settle();

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
